/* src/fpms_pkg.sv */
// Shared types and codes for the fixed-point matrix stack.
// No dependencies; used by fixed_point_matrix_stack.
`default_nettype none

package fpms_pkg;

	localparam int WORD_W = 32;
	localparam int ROW_WORDS = 4;
	localparam int ROWS_PER_MATRIX = 3;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [ROW_WORDS-1:0] row_t;

	// Operation codes carried by the func field.
	localparam logic [2:0] FUNC_PUSH = 3'd0;
	localparam logic [2:0] FUNC_PUSH_UNIT = 3'd1;
	localparam logic [2:0] FUNC_POP = 3'd2;
	localparam logic [2:0] FUNC_TRANS_REL = 3'd3;
	localparam logic [2:0] FUNC_TRANS_ABS = 3'd4;
	localparam logic [2:0] FUNC_ROT_X = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] CFG_FAR_LIMIT = 2'd0;
	localparam logic [1:0] CFG_VIEW_X = 2'd1;
	localparam logic [1:0] CFG_VIEW_Y = 2'd2;
	localparam logic [1:0] CFG_VIEW_Z = 2'd3;

	localparam logic [30:0] FAR_LIMIT_RESET = 31'd335544320;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

/* src/fixed_point_matrix_stack.sv */
// Fixed-point 3x4 matrix stack: top level with the row memory and the row pipeline.
// Depends on fpms_pkg for types, operation codes and register indexes.
`default_nettype none

// The block keeps a stack of STACK_DEPTH transform matrices of 3 rows by 4 words
// and applies one operation per request: push, push with a unit rotation, pop,
// relative or absolute translate, and rotation about x. Each request returns one
// result with in_range, fault and depth. The matrices live in one synchronous
// memory with one row (four 32-bit words) per entry, read through a register.
// An operation on the matrix streams its three rows through the memory:
// one row read per cycle, a stage of four shared 32x32 multipliers, then an add
// stage that writes the row back. Push, push-unit, the translates and a non-trivial
// rotation stream their rows this way; pop, a faulting push or pop, a zero
// rotation and the unused codes skip the memory and go straight to the result.
// The single row port and two-stage pipeline set the pace. A request is taken while
// the previous result still waits in the output register. Each memory row has a
// valid bit cleared at reset, so a row never written reads as zero and no clearing
// pass is needed after reset. Configuration writes are always accepted and must
// only be issued while the block is idle.
module fixed_point_matrix_stack #(
	parameter int FRAC_BITS = 14,
	parameter int STACK_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  func,
	input  wire logic [31:0] offset_x,
	input  wire logic [31:0] offset_y,
	input  wire logic [31:0] offset_z,
	input  wire logic [15:0] sine_value,
	input  wire logic [15:0] cosine_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             in_range,
	output logic             fault,
	output logic [4:0]       depth,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int SW = $clog2(STACK_DEPTH);
	localparam int ROWS = STACK_DEPTH * fpms_pkg::ROWS_PER_MATRIX;
	localparam int AW = $clog2(ROWS);
	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
	localparam logic [SW-1:0] TOP_MAX = SW'(STACK_DEPTH - 1);

	// First row address of a matrix slot: slot * 3.
	function automatic logic [AW-1:0] slot_base(input logic [SW-1:0] slot);
		return (AW'(slot) << 1) + AW'(slot);
	endfunction

	// Configuration registers.
	logic [30:0] far_limit_q;
	logic [31:0] view_x_q;
	logic [31:0] view_y_q;
	logic [31:0] view_z_q;

	// Control.
	fpms_pkg::state_t state_q, state_d;
	logic [SW-1:0] top_q;
	logic [1:0] cnt_q;
	logic accept;
	logic issue;
	logic load_out;

	// Decode of the incoming request.
	logic [SW-1:0] top_d;
	logic [SW-1:0] src_slot;
	logic [SW-1:0] dst_slot;
	logic fault_d;
	logic mem_op;

	// Request held for the duration of the operation.
	logic [2:0] op_q;
	logic [AW-1:0] src_base_q;
	logic [AW-1:0] dst_base_q;
	logic [31:0] opx_q;
	logic [31:0] opy_q;
	logic [31:0] opz_q;
	logic [31:0] sin_q;
	logic [31:0] cos_q;
	logic fault_q;
	logic ok_q;

	// Row memory with one valid bit per row.
	fpms_pkg::row_t mem_q [ROWS];
	logic [ROWS-1:0] row_vld_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic wr_en;
	fpms_pkg::row_t wr_row;

	// Pipeline stages.
	logic vld_s1;
	logic [1:0] row_idx_s1;
	fpms_pkg::row_t rd_row_s1;
	logic rd_vld_s1;
	fpms_pkg::row_t row_m;
	fpms_pkg::word_t mul_a [4];
	fpms_pkg::word_t mul_b [4];
	logic vld_s2;
	logic [1:0] row_idx_s2;
	fpms_pkg::row_t row_data_s2;
	fpms_pkg::word_t prod_s2 [4];

	// Write-back stage results.
	logic [31:0] trans_sum;
	logic [31:0] rot_s0;
	logic [31:0] rot_s1;
	logic [31:0] trans_mag;
	logic is_far;

	// Output register.
	logic out_valid_q;
	logic in_range_q;
	logic fault_out_q;
	logic [4:0] depth_q;

	logic [31:0] sin_in;
	logic [31:0] cos_in;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == fpms_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign in_range = in_range_q;
	assign fault = fault_out_q;
	assign depth = depth_q;

	assign sin_in = {{16{sine_value[15]}}, sine_value};
	assign cos_in = {{16{cosine_value[15]}}, cosine_value};

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_limit_q <= fpms_pkg::FAR_LIMIT_RESET;
			view_x_q <= '0;
			view_y_q <= '0;
			view_z_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				fpms_pkg::CFG_FAR_LIMIT: far_limit_q <= cfg_data[30:0];
				fpms_pkg::CFG_VIEW_X: view_x_q <= cfg_data;
				fpms_pkg::CFG_VIEW_Y: view_y_q <= cfg_data;
				fpms_pkg::CFG_VIEW_Z: view_z_q <= cfg_data;
				default: far_limit_q <= far_limit_q;
			endcase
		end
	end

	// Request decode: the new top, the fault flag and the slots to read and write.
	// The top index moves at acceptance, so the result reports the top after the
	// operation while the row pipeline works from the captured slot bases.
	always_comb begin
		top_d = top_q;
		src_slot = top_q;
		dst_slot = top_q;
		fault_d = 1'b0;
		mem_op = 1'b0;
		case (func)
			fpms_pkg::FUNC_PUSH, fpms_pkg::FUNC_PUSH_UNIT: begin
				if (top_q == TOP_MAX) begin
					fault_d = 1'b1;
				end else begin
					top_d = top_q + 1'b1;
					dst_slot = top_q + 1'b1;
					// Push-unit keeps the translations already in the new slot.
					src_slot = (func == fpms_pkg::FUNC_PUSH) ? top_q : top_q + 1'b1;
					mem_op = 1'b1;
				end
			end
			fpms_pkg::FUNC_POP: begin
				if (top_q == '0) begin
					fault_d = 1'b1;
				end else begin
					top_d = top_q - 1'b1;
				end
			end
			fpms_pkg::FUNC_TRANS_REL, fpms_pkg::FUNC_TRANS_ABS: begin
				mem_op = 1'b1;
			end
			fpms_pkg::FUNC_ROT_X: begin
				// A zero angle leaves the matrix exactly as it is.
				mem_op = !((sin_in == '0) && (cos_in == ONE));
			end
			default: mem_op = 1'b0;
		endcase
	end

	// Sequencer: next state and the strobes for acceptance, row reads and result.
	always_comb begin
		state_d = state_q;
		accept = 1'b0;
		issue = 1'b0;
		load_out = 1'b0;
		case (state_q)
			fpms_pkg::ST_IDLE: begin
				if (in_valid) begin
					accept = 1'b1;
					state_d = mem_op ? fpms_pkg::ST_RUN : fpms_pkg::ST_DONE;
				end
			end
			fpms_pkg::ST_RUN: begin
				issue = (cnt_q != 2'd3);
				if (vld_s2 && (row_idx_s2 == 2'd2)) begin
					state_d = fpms_pkg::ST_DONE;
				end
			end
			fpms_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = fpms_pkg::ST_IDLE;
				end
			end
			default: state_d = fpms_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpms_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			cnt_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			row_vld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				top_q <= top_d;
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Operands captured at acceptance; absolute translate subtracts the view origin.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= func;
			src_base_q <= slot_base(src_slot);
			dst_base_q <= slot_base(dst_slot);
			if (func == fpms_pkg::FUNC_TRANS_ABS) begin
				opx_q <= offset_x - view_x_q;
				opy_q <= offset_y - view_y_q;
				opz_q <= offset_z - view_z_q;
			end else begin
				opx_q <= offset_x;
				opy_q <= offset_y;
				opz_q <= offset_z;
			end
			sin_q <= sin_in;
			cos_q <= cos_in;
			fault_q <= fault_d;
		end
	end

	// Rows are read one per cycle and written back from the second stage. Within an
	// operation each row address is read and written once, and the write of a
	// row never meets a read of the same row in the same cycle, so no forwarding
	// is required.
	assign rd_addr = src_base_q + AW'(cnt_q);
	assign wr_addr = dst_base_q + AW'(row_idx_s2);
	assign wr_en = vld_s2;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
		if (issue) begin
			rd_row_s1 <= mem_q[rd_addr];
			rd_vld_s1 <= row_vld_q[rd_addr];
			row_idx_s1 <= cnt_q;
		end
	end

	// Stage 1: a row never written reads as zero; the four multipliers are shared
	// between the translate dot products and the rotation terms.
	assign row_m = rd_vld_s1 ? rd_row_s1 : '0;

	always_comb begin
		if (op_q == fpms_pkg::FUNC_ROT_X) begin
			mul_a[0] = cos_q;
			mul_b[0] = row_m[1];
			mul_a[1] = sin_q;
			mul_b[1] = row_m[2];
			mul_a[2] = cos_q;
			mul_b[2] = row_m[2];
			mul_a[3] = sin_q;
			mul_b[3] = row_m[1];
		end else begin
			mul_a[0] = opx_q;
			mul_b[0] = row_m[0];
			mul_a[1] = opy_q;
			mul_b[1] = row_m[1];
			mul_a[2] = opz_q;
			mul_b[2] = row_m[2];
			mul_a[3] = '0;
			mul_b[3] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			for (int i = 0; i < 4; i++) begin
				prod_s2[i] <= mul_a[i] * mul_b[i];
			end
			row_data_s2 <= row_m;
			row_idx_s2 <= row_idx_s1;
		end
	end

	// Stage 2: form the new row and write it back.
	assign trans_sum = prod_s2[0] + prod_s2[1] + prod_s2[2];
	assign rot_s0 = prod_s2[0] + prod_s2[1];
	assign rot_s1 = prod_s2[2] - prod_s2[3];

	always_comb begin
		wr_row = row_data_s2;
		case (op_q)
			fpms_pkg::FUNC_PUSH_UNIT: begin
				wr_row[0] = (row_idx_s2 == 2'd0) ? ONE : '0;
				wr_row[1] = (row_idx_s2 == 2'd1) ? ONE : '0;
				wr_row[2] = (row_idx_s2 == 2'd2) ? ONE : '0;
			end
			fpms_pkg::FUNC_TRANS_REL: wr_row[3] = row_data_s2[3] + trans_sum;
			fpms_pkg::FUNC_TRANS_ABS: wr_row[3] = trans_sum;
			fpms_pkg::FUNC_ROT_X: begin
				wr_row[1] = 32'($signed(rot_s0) >>> FRAC_BITS);
				wr_row[2] = 32'($signed(rot_s1) >>> FRAC_BITS);
			end
			default: wr_row = row_data_s2;
		endcase
	end

	// The most negative translation has magnitude 2^31 and always exceeds the far limit.
	assign trans_mag = wr_row[3][31] ? (32'd0 - wr_row[3]) : wr_row[3];
	assign is_far = trans_mag > {1'b0, far_limit_q};

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q <= 1'b1;
		end else if (vld_s2 && (op_q == fpms_pkg::FUNC_TRANS_REL) && is_far) begin
			ok_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			in_range_q <= ok_q;
			fault_out_q <= fault_q;
			depth_q <= 5'(top_q);
		end
	end

`ifndef SYNTHESIS
	// Every row write lands in the slot that is the top after the operation.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (dst_base_q == slot_base(top_q)))
		else $error("row write outside the top matrix");

	// The top index never passes the last slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TOP_MAX)
		else $error("top index beyond stack depth");

	// A result appears only after the sequencer has finished the request.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == fpms_pkg::ST_DONE))
		else $error("result raised outside the completion state");

	// No request is accepted while rows of the previous one are still in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 || vld_s2) |-> !in_ready)
		else $error("request accepted with rows in flight");
`endif

endmodule

`default_nettype wire
